// File: rtl/html_entity_decoder_core_defines.svh
// Assertion macros for the entity decoder RTL, used by hed_fifo.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef HTML_ENTITY_DECODER_CORE_DEFINES_SVH
`define HTML_ENTITY_DECODER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define HED_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define HED_ASSERT(lbl, clk, rst_n, prop)
`define HED_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/hed_pkg.sv
// Package of the entity decoder: trie tables, queue entry and back-end types.
// No dependencies; used by every module of the block.
package hed_pkg;

    localparam int NODE_W     = 5;
    localparam int IDX_W      = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [NODE_W-1:0] NODE_IDLE = '0;
    localparam logic [NODE_W-1:0] NODE_AMP  = 5'd1;
    localparam logic [7:0]        CH_SEMI   = 8'h3b;
    localparam logic [7:0]        CH_AMP    = 8'h26;

    typedef enum logic [1:0] {
        PH_A,
        PH_S,
        PH_B
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [IDX_W-1:0] idx;
    } t_pos;

    // One queue entry: a held prefix, an optional single byte, a trailing prefix.
    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic              single;
        logic [7:0]        sch;
        logic              sent;
        logic [NODE_W-1:0] node_b;
        logic              eos;
    } t_entry;

    function automatic logic [NODE_W-1:0] node_child(logic [NODE_W-1:0] node, logic [7:0] c);
        logic [NODE_W-1:0] r;
        r = NODE_IDLE;
        unique case (node)
            5'd0:  if (c == CH_AMP) r = NODE_AMP;
            5'd1: begin
                if (c == "a") r = 5'd2;
                if (c == "q") r = 5'd8;
                if (c == "l") r = 5'd12;
                if (c == "g") r = 5'd14;
                if (c == "#") r = 5'd16;
            end
            5'd2: begin
                if (c == "m") r = 5'd3;
                if (c == "p") r = 5'd5;
            end
            5'd3:  if (c == "p") r = 5'd4;
            5'd5:  if (c == "o") r = 5'd6;
            5'd6:  if (c == "s") r = 5'd7;
            5'd8:  if (c == "u") r = 5'd9;
            5'd9:  if (c == "o") r = 5'd10;
            5'd10: if (c == "t") r = 5'd11;
            5'd12: if (c == "t") r = 5'd13;
            5'd14: if (c == "t") r = 5'd15;
            5'd16: begin
                if (c == "3") r = 5'd17;
                if (c == "6") r = 5'd21;
            end
            5'd17: begin
                if (c == "4") r = 5'd18;
                if (c == "8") r = 5'd19;
                if (c == "9") r = 5'd20;
            end
            5'd21: begin
                if (c == "0") r = 5'd22;
                if (c == "2") r = 5'd23;
            end
            default: r = NODE_IDLE;
        endcase
        return r;
    endfunction

    // Held text of a node, first character in the top byte.
    function automatic logic [39:0] node_text(logic [NODE_W-1:0] node);
        logic [39:0] t;
        unique case (node)
            5'd1:    t = {"&",     32'h0};
            5'd2:    t = {"&a",    24'h0};
            5'd3:    t = {"&am",   16'h0};
            5'd4:    t = {"&amp",   8'h0};
            5'd5:    t = {"&ap",   16'h0};
            5'd6:    t = {"&apo",   8'h0};
            5'd7:    t = "&apos";
            5'd8:    t = {"&q",    24'h0};
            5'd9:    t = {"&qu",   16'h0};
            5'd10:   t = {"&quo",   8'h0};
            5'd11:   t = "&quot";
            5'd12:   t = {"&l",    24'h0};
            5'd13:   t = {"&lt",   16'h0};
            5'd14:   t = {"&g",    24'h0};
            5'd15:   t = {"&gt",   16'h0};
            5'd16:   t = {"&#",    24'h0};
            5'd17:   t = {"&#3",   16'h0};
            5'd18:   t = {"&#34",   8'h0};
            5'd19:   t = {"&#38",   8'h0};
            5'd20:   t = {"&#39",   8'h0};
            5'd21:   t = {"&#6",   16'h0};
            5'd22:   t = {"&#60",   8'h0};
            5'd23:   t = {"&#62",   8'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [IDX_W-1:0] node_len(logic [NODE_W-1:0] node);
        logic [IDX_W-1:0] l;
        unique case (node)
            5'd1:                                     l = 3'd1;
            5'd2, 5'd8, 5'd12, 5'd14, 5'd16:          l = 3'd2;
            5'd3, 5'd5, 5'd9, 5'd13, 5'd15, 5'd17, 5'd21: l = 3'd3;
            5'd4, 5'd6, 5'd10, 5'd18, 5'd19, 5'd20, 5'd22, 5'd23: l = 3'd4;
            5'd7, 5'd11:                              l = 3'd5;
            default:                                  l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] node_value(logic [NODE_W-1:0] node);
        logic [7:0] v;
        unique case (node)
            5'd4, 5'd19:  v = "&";
            5'd7, 5'd20:  v = "'";
            5'd11, 5'd18: v = "\"";
            5'd13, 5'd22: v = "<";
            5'd15, 5'd23: v = ">";
            default:      v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] node_char(logic [NODE_W-1:0] node, logic [IDX_W-1:0] idx);
        logic [39:0] t;
        logic [5:0]  sh;
        t  = node_text(node);
        sh = {3'd4 - idx, 3'b000};
        return t[sh +: 8];
    endfunction

endpackage

// File: rtl/hed_front.sv
// Front end of the entity decoder: accepts bytes, walks the trie, builds queue entries.
// Depends on hed_pkg.
module hed_front
    import hed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_eos,
    input  logic       i_space,
    output logic       o_ready,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] n_node;
    logic [NODE_W-1:0] w_child;
    logic [NODE_W-1:0] w_restart;
    logic [NODE_W-1:0] w_after;
    logic [7:0]        w_value;
    logic              w_accept;

    assign o_ready  = i_space;
    assign w_accept = i_valid && o_ready;
    assign w_value  = node_value(r_node);
    assign w_child  = node_child(r_node, i_char);
    assign w_restart = node_child(NODE_IDLE, i_char);

    always_comb begin
        o_entry = '0;
        o_entry.eos = i_eos;
        o_entry.sch = i_char;
        priority if (r_node != NODE_IDLE && w_value != 8'h00 && i_char == CH_SEMI) begin
            o_entry.single = 1'b1;
            o_entry.sch    = w_value;
            o_entry.sent   = 1'b1;
            w_after        = NODE_IDLE;
        end else if (w_child != NODE_IDLE) begin
            w_after = w_child;
        end else begin
            o_entry.node_a = r_node;
            o_entry.single = (w_restart == NODE_IDLE);
            w_after        = w_restart;
        end
        o_entry.node_b = i_eos ? w_after : NODE_IDLE;
        n_node = i_eos ? NODE_IDLE : w_after;
    end

    assign o_push = w_accept && (o_entry.node_a != NODE_IDLE || o_entry.single
                                 || o_entry.node_b != NODE_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= NODE_IDLE;
        end else if (w_accept) begin
            r_node <= n_node;
        end
    end

endmodule

// File: rtl/hed_fifo.sv
// Short entry queue between the front and back ends of the entity decoder.
// Depends on hed_pkg and the assertion macro header.
`include "html_entity_decoder_core_defines.svh"
module hed_fifo
    import hed_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_space,
    output logic   o_avail,
    output t_entry o_head
);

    t_entry               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;

    assign o_space = (r_count != FIFO_CW'(FIFO_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + FIFO_CW'(i_push) - FIFO_CW'(i_pop);
        end
    end

    `HED_NEVER(a_push_when_full, i_clk, i_rst_n, i_push && !o_space)
    `HED_NEVER(a_pop_when_empty, i_clk, i_rst_n, i_pop && !o_avail)
    `HED_NEVER(a_count_bound, i_clk, i_rst_n, r_count > FIFO_CW'(FIFO_DEPTH))
    `HED_ASSERT(a_count_track, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

// File: rtl/hed_back.sv
// Back end of the entity decoder: expands each queue entry into output bytes.
// Depends on hed_pkg.
module hed_back
    import hed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_avail,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char,
    output logic       o_entity,
    output logic       o_last
);

    t_pos r_pos;
    t_pos n_pos;
    t_pos w_cur;
    t_pos w_adv;
    t_pos w_nxt;
    logic w_final;
    logic w_fire;

    function automatic t_pos normalize(t_pos p, t_entry e);
        t_pos q;
        q = p;
        if (q.phase == PH_A && q.idx >= node_len(e.node_a)) begin
            q.phase = PH_S;
            q.idx   = '0;
        end
        if (q.phase == PH_S && !e.single) begin
            q.phase = PH_B;
            q.idx   = '0;
        end
        return q;
    endfunction

    always_comb begin
        w_cur = normalize(r_pos, i_head);
        w_adv = w_cur;
        if (w_cur.phase == PH_S) begin
            w_adv.phase = PH_B;
            w_adv.idx   = '0;
        end else begin
            w_adv.idx = w_cur.idx + 1'b1;
        end
        w_nxt   = normalize(w_adv, i_head);
        w_final = (w_nxt.phase == PH_B) && (w_nxt.idx >= node_len(i_head.node_b));
        w_fire  = i_avail && i_ready;
    end

    always_comb begin
        n_pos = r_pos;
        if (w_fire) begin
            if (w_final) begin
                n_pos.phase = PH_A;
                n_pos.idx   = '0;
            end else begin
                n_pos = w_nxt;
            end
        end
    end

    always_comb begin
        o_valid  = i_avail;
        o_pop    = w_fire && w_final;
        o_last   = w_final && i_head.eos;
        o_entity = 1'b0;
        unique case (w_cur.phase)
            PH_A:    o_char = node_char(i_head.node_a, w_cur.idx);
            PH_S: begin
                o_char   = i_head.sch;
                o_entity = i_head.sent;
            end
            PH_B:    o_char = node_char(i_head.node_b, w_cur.idx);
            default: o_char = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos.phase <= PH_A;
            r_pos.idx   <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// File: rtl/html_entity_decoder_core.sv
// Entity decoder top level: byte stream in, decoded byte stream out.
// Instantiates hed_front, hed_fifo and hed_back; depends on hed_pkg.
//
// Usage: bytes enter on the slave stream, one per transaction, with tlast on
// the final byte of each string. Decoded bytes leave on the master stream,
// tuser set on a byte that replaced an entity and tlast on the final output
// byte of a string. A byte that only extends a partial entity produces no
// output yet; its bytes appear later, either as one decoded byte or flushed
// unchanged in order. The front end accepts one byte per cycle while the
// four-entry queue has room. The back end emits one output byte per cycle
// while the queue holds an entry and the receiver is ready; a flush emits
// a held prefix of up to five bytes, then the current byte. With the queue
// empty, a byte that pushes an entry shows its first output byte in the
// cycle after it is accepted. When the receiver stalls, the queue fills and
// tready drops at four pending entries. Reset clears the trie state and the queue.
module html_entity_decoder_core
    import hed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    input  logic       i_s_tlast,   // end_of_string
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] char_out
    output logic       o_m_tuser,   // [0] from_entity
    output logic       o_m_tlast    // last_out
);

    logic   w_space;
    logic   w_avail;
    logic   w_push;
    logic   w_pop;
    t_entry w_entry;
    t_entry w_head;

    hed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_char  (i_s_tdata),
        .i_eos   (i_s_tlast),
        .i_space (w_space),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    hed_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_space (w_space),
        .o_avail (w_avail),
        .o_head  (w_head)
    );

    hed_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_avail),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_char   (o_m_tdata),
        .o_entity (o_m_tuser),
        .o_last   (o_m_tlast)
    );

endmodule
